// File: hdl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, sizes and address helpers of the go-back-N sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int DATA_W      = 32;
    localparam int WAIT_DEPTH  = 16;
    localparam int UNACK_DEPTH = 16;

    localparam int WPTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int UPTR_W = (UNACK_DEPTH > 1) ? $clog2(UNACK_DEPTH) : 1;
    localparam int WCNT_W = $clog2(WAIT_DEPTH + 1);
    localparam int UCNT_W = $clog2(UNACK_DEPTH + 1);
    localparam int OCC_W  = ((WCNT_W > UCNT_W) ? WCNT_W : UCNT_W) + 1;

    typedef enum logic [1:0] {
        MODE_NEW  = 2'd0,
        MODE_DONE = 2'd1,
        MODE_ACK  = 2'd2,
        MODE_NACK = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        SND_IDLE   = 2'd0,
        SND_NEW    = 2'd1,
        SND_REPLAY = 2'd2
    } snd_state_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_EXEC = 2'd1,
        CTL_OUT  = 2'd2
    } ctl_state_t;

    typedef enum logic [1:0] {
        RES_NONE  = 2'd0,
        RES_INPUT = 2'd1,
        RES_WAIT  = 2'd2,
        RES_UNACK = 2'd3
    } res_src_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic out_load;
    } gbn_cmd_t;

    typedef struct packed {
        logic has_result;
        logic out_free;
    } gbn_status_t;

    function automatic logic [UPTR_W-1:0] uaddr(input logic [UPTR_W-1:0] base,
                                                input logic [UCNT_W-1:0] off);
        logic [UPTR_W:0] sum;
        sum = (UPTR_W+1)'(base) + (UPTR_W+1)'(off);
        if (sum >= (UPTR_W+1)'(UNACK_DEPTH)) begin
            sum = sum - (UPTR_W+1)'(UNACK_DEPTH);
        end
        return sum[UPTR_W-1:0];
    endfunction

    function automatic logic [WPTR_W-1:0] waddr(input logic [WPTR_W-1:0] base,
                                                input logic [WCNT_W-1:0] off);
        logic [WPTR_W:0] sum;
        sum = (WPTR_W+1)'(base) + (WPTR_W+1)'(off);
        if (sum >= (WPTR_W+1)'(WAIT_DEPTH)) begin
            sum = sum - (WPTR_W+1)'(WAIT_DEPTH);
        end
        return sum[WPTR_W-1:0];
    endfunction

endpackage

// File: hdl/go_back_n_sender_unit.sv
// ----------------------------------------------------------------------------
// go_back_n_sender_unit
// Go-back-N ARQ sender with a wait fifo and an unacknowledged store.
// ----------------------------------------------------------------------------
// Each transaction is captured, then an update step changes the sender
// state and reads the fifo or store memory; the result then sits in the
// output register while the next transaction is captured. Input waits
// during the update step, as set by the registered memory read and the
// write-back of a descriptor moved from the wait fifo into the store. A
// stalled result output holds off input only when a second result is due.
module go_back_n_sender_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // packet_data
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // send_data
    output logic [1:0]  m_tuser    // is_retransmit, dropped
);

    gbn_pkg::gbn_cmd_t    ctrl_cmd;
    gbn_pkg::gbn_status_t ctrl_status;

    gbn_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (ctrl_status),
        .cmd      (ctrl_cmd)
    );

    gbn_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (ctrl_cmd),
        .status   (ctrl_status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    a_accept_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.accept |=> ctrl_cmd.exec)
        else $error("accepted transaction not executed");

    a_exec_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.exec |-> !s_tready)
        else $error("input ready during execute step");

    a_load_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_no_result_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.exec && !ctrl_status.has_result |=> !ctrl_cmd.out_load)
        else $error("output loaded for an event without result");
`endif

endmodule

// File: hdl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: takes one transaction, runs its update step, then hands the
// result, if any, to the output register.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  gbn_pkg::gbn_status_t status,
    output gbn_pkg::gbn_cmd_t    cmd
);

    gbn_pkg::ctl_state_t state_reg;
    gbn_pkg::ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= gbn_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.exec     = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            gbn_pkg::CTL_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = gbn_pkg::CTL_EXEC;
                end
            end
            gbn_pkg::CTL_EXEC: begin
                cmd.exec = 1'b1;
                if (status.has_result) begin
                    state_next = gbn_pkg::CTL_OUT;
                end else begin
                    state_next = gbn_pkg::CTL_IDLE;
                end
            end
            gbn_pkg::CTL_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    s_tready     = 1'b1;
                    if (s_tvalid) begin
                        cmd.accept = 1'b1;
                        state_next = gbn_pkg::CTL_EXEC;
                    end else begin
                        state_next = gbn_pkg::CTL_IDLE;
                    end
                end
            end
            default: begin
                state_next = gbn_pkg::CTL_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/gbn_dpath.sv
// ----------------------------------------------------------------------------
// gbn_dpath
// Sender state, wait FIFO and unacknowledged store memories, event decode
// and the output register.
// ----------------------------------------------------------------------------
module gbn_dpath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  gbn_pkg::gbn_cmd_t           cmd,
    output gbn_pkg::gbn_status_t        status,
    input  logic [gbn_pkg::DATA_W-1:0]  s_tdata,
    input  logic [1:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [gbn_pkg::DATA_W-1:0]  m_tdata,
    output logic [1:0]                  m_tuser
);

    localparam int DW  = gbn_pkg::DATA_W;
    localparam int WPW = gbn_pkg::WPTR_W;
    localparam int UPW = gbn_pkg::UPTR_W;
    localparam int WCW = gbn_pkg::WCNT_W;
    localparam int UCW = gbn_pkg::UCNT_W;
    localparam int OCW = gbn_pkg::OCC_W;

    // input transaction
    gbn_pkg::mode_t      in_mode_reg;
    logic [DW-1:0]       in_data_reg;

    // sender state
    gbn_pkg::snd_state_t snd_reg, snd_next;
    logic [WPW-1:0]      whead_reg, whead_next;
    logic [WCW-1:0]      wcnt_reg, wcnt_next;
    logic [UPW-1:0]      uhead_reg, uhead_next;
    logic [UCW-1:0]      ucnt_reg, ucnt_next;
    logic [UCW-1:0]      ridx_reg, ridx_next;
    logic [UCW-1:0]      rend_reg, rend_next;

    // pending result
    gbn_pkg::res_src_t   src_reg, src_next;
    logic                retx_reg, retx_next;
    logic                drop_reg, drop_next;
    logic                push_reg, push_next;
    logic [UPW-1:0]      push_addr_reg, push_addr_next;

    // memories
    logic [DW-1:0]       wait_mem [gbn_pkg::WAIT_DEPTH];
    logic [DW-1:0]       unack_mem [gbn_pkg::UNACK_DEPTH];
    logic [DW-1:0]       wait_rdata_reg;
    logic [DW-1:0]       unack_rdata_reg;
    logic                wait_we, wait_re, unack_we_exec, unack_re;
    logic [UPW-1:0]      unack_raddr;
    logic                unack_we;
    logic [UPW-1:0]      unack_waddr;
    logic [DW-1:0]       unack_wdata;

    // output register
    logic                m_tvalid_reg;
    logic [DW-1:0]       out_data_reg;
    logic                out_retx_reg;
    logic                out_drop_reg;
    logic [DW-1:0]       out_data_sel;

    // derived
    logic [UPW-1:0]      u_tail;
    logic [WPW-1:0]      w_tail;
    logic [OCW-1:0]      occupancy;
    logic                unack_full;
    logic                wait_block;
    logic                can_send_new;
    logic                go_new;

    assign u_tail     = gbn_pkg::uaddr(uhead_reg, ucnt_reg);
    assign w_tail     = gbn_pkg::waddr(whead_reg, wcnt_reg);
    assign occupancy  = OCW'(wcnt_reg) + OCW'(ucnt_reg);
    assign unack_full = ucnt_reg >= UCW'(gbn_pkg::UNACK_DEPTH);
    assign wait_block = (wcnt_reg >= WCW'(gbn_pkg::WAIT_DEPTH))
                     || (occupancy >= OCW'(gbn_pkg::UNACK_DEPTH));
    assign can_send_new = (wcnt_reg != '0) && !unack_full;

    always_comb begin
        snd_next       = snd_reg;
        whead_next     = whead_reg;
        wcnt_next      = wcnt_reg;
        uhead_next     = uhead_reg;
        ucnt_next      = ucnt_reg;
        ridx_next      = ridx_reg;
        rend_next      = rend_reg;
        src_next       = gbn_pkg::RES_NONE;
        retx_next      = 1'b0;
        drop_next      = 1'b0;
        push_next      = 1'b0;
        push_addr_next = u_tail;
        wait_we        = 1'b0;
        wait_re        = 1'b0;
        unack_we_exec  = 1'b0;
        unack_re       = 1'b0;
        unack_raddr    = gbn_pkg::uaddr(uhead_reg, ridx_reg);
        go_new         = 1'b0;
        unique case (in_mode_reg)
            gbn_pkg::MODE_NEW: begin
                src_next = gbn_pkg::RES_INPUT;
                if (snd_reg == gbn_pkg::SND_IDLE) begin
                    if (unack_full) begin
                        drop_next = 1'b1;
                    end else begin
                        unack_we_exec = 1'b1;
                        ucnt_next     = ucnt_reg + 1'b1;
                        snd_next      = gbn_pkg::SND_NEW;
                    end
                end else if (wait_block) begin
                    drop_next = 1'b1;
                end else begin
                    src_next  = gbn_pkg::RES_NONE;
                    wait_we   = 1'b1;
                    wcnt_next = wcnt_reg + 1'b1;
                end
            end
            gbn_pkg::MODE_DONE: begin
                unique case (snd_reg)
                    gbn_pkg::SND_NEW: begin
                        go_new = 1'b1;
                    end
                    gbn_pkg::SND_REPLAY: begin
                        if ((ridx_reg < rend_reg) && (ridx_reg < ucnt_reg)) begin
                            unack_re  = 1'b1;
                            ridx_next = ridx_reg + 1'b1;
                            src_next  = gbn_pkg::RES_UNACK;
                            retx_next = 1'b1;
                        end else begin
                            go_new = 1'b1;
                        end
                    end
                    default: begin
                        go_new = 1'b0;
                    end
                endcase
            end
            gbn_pkg::MODE_ACK: begin
                if (ucnt_reg != '0) begin
                    uhead_next = gbn_pkg::uaddr(uhead_reg, UCW'(1));
                    ucnt_next  = ucnt_reg - 1'b1;
                    if (ridx_reg != '0) begin
                        ridx_next = ridx_reg - 1'b1;
                    end
                    if (rend_reg != '0) begin
                        rend_next = rend_reg - 1'b1;
                    end
                end
            end
            gbn_pkg::MODE_NACK: begin
                if (ucnt_reg != '0) begin
                    rend_next = ucnt_reg;
                    snd_next  = gbn_pkg::SND_REPLAY;
                    if (snd_reg == gbn_pkg::SND_IDLE) begin
                        ridx_next   = UCW'(1);
                        unack_re    = 1'b1;
                        unack_raddr = uhead_reg;
                        src_next    = gbn_pkg::RES_UNACK;
                        retx_next   = 1'b1;
                    end else begin
                        ridx_next = '0;
                    end
                end
            end
            default: begin
                src_next = gbn_pkg::RES_NONE;
            end
        endcase
        if (go_new) begin
            if (can_send_new) begin
                wait_re    = 1'b1;
                whead_next = gbn_pkg::waddr(whead_reg, WCW'(1));
                wcnt_next  = wcnt_reg - 1'b1;
                push_next  = 1'b1;
                ucnt_next  = ucnt_reg + 1'b1;
                snd_next   = gbn_pkg::SND_NEW;
                src_next   = gbn_pkg::RES_WAIT;
            end else begin
                snd_next = gbn_pkg::SND_IDLE;
            end
        end
    end

    // input capture and pending result
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            in_mode_reg <= gbn_pkg::mode_t'(s_tuser);
            in_data_reg <= s_tdata;
        end
        if (cmd.exec) begin
            src_reg       <= src_next;
            retx_reg      <= retx_next;
            drop_reg      <= drop_next;
            push_addr_reg <= push_addr_next;
        end
    end

    // sender state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            snd_reg   <= gbn_pkg::SND_IDLE;
            whead_reg <= '0;
            wcnt_reg  <= '0;
            uhead_reg <= '0;
            ucnt_reg  <= '0;
            ridx_reg  <= '0;
            rend_reg  <= '0;
            push_reg  <= 1'b0;
        end else if (cmd.exec) begin
            snd_reg   <= snd_next;
            whead_reg <= whead_next;
            wcnt_reg  <= wcnt_next;
            uhead_reg <= uhead_next;
            ucnt_reg  <= ucnt_next;
            ridx_reg  <= ridx_next;
            rend_reg  <= rend_next;
            push_reg  <= push_next;
        end
    end

    // wait fifo memory
    always_ff @(posedge aclk) begin
        if (cmd.exec && wait_we) begin
            wait_mem[w_tail] <= in_data_reg;
        end
        if (cmd.exec && wait_re) begin
            wait_rdata_reg <= wait_mem[whead_reg];
        end
    end

    // unacked store memory, descriptor moved from the wait fifo written back
    assign unack_we    = (cmd.exec && unack_we_exec) || (cmd.out_load && push_reg);
    assign unack_waddr = cmd.out_load ? push_addr_reg : u_tail;
    assign unack_wdata = cmd.out_load ? wait_rdata_reg : in_data_reg;

    always_ff @(posedge aclk) begin
        if (unack_we) begin
            unack_mem[unack_waddr] <= unack_wdata;
        end
        if (cmd.exec && unack_re) begin
            unack_rdata_reg <= unack_mem[unack_raddr];
        end
    end

    // output register
    always_comb begin
        unique case (src_reg)
            gbn_pkg::RES_WAIT:  out_data_sel = wait_rdata_reg;
            gbn_pkg::RES_UNACK: out_data_sel = unack_rdata_reg;
            default:            out_data_sel = in_data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= out_data_sel;
            out_retx_reg <= retx_reg;
            out_drop_reg <= drop_reg;
        end
    end

    assign status.has_result = (src_next != gbn_pkg::RES_NONE);
    assign status.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_drop_reg, out_retx_reg};

endmodule
